@@ design/sssg_pkg.sv @@
// ----------------------------------------------------------------------------
// sssg_pkg
// Shared types and constants for the S-curve stepper step generator.
// ----------------------------------------------------------------------------
package sssg_pkg;

    localparam logic [8:0]  DT_Q16     = 9'd327;
    localparam logic [31:0] SQRT_BIT0  = 32'h4000_0000;
    localparam int unsigned MUL_STEPS  = 16;
    localparam int unsigned DIV_STEPS  = 32;
    localparam int unsigned SQRT_STEPS = 16;

    localparam logic [15:0] RST_TICK_RATE = 16'd20000;
    localparam logic [8:0]  RST_MICRO     = 9'd16;
    localparam logic [15:0] RST_MIN_SPEED = 16'd100;
    localparam logic [15:0] RST_MAX_SPEED = 16'd16000;
    localparam logic [15:0] RST_START_FS  = 16'd50;
    localparam logic [14:0] RST_ACCEL     = 15'd10000;
    localparam logic [14:0] RST_JERK      = 15'd20000;
    localparam logic [9:0]  RST_PERIOD    = 10'd100;

    typedef enum logic [2:0] {
        CFG_TICK_RATE,
        CFG_MICROSTEPS,
        CFG_MIN_SPEED,
        CFG_MAX_SPEED,
        CFG_START_SPEED,
        CFG_ACCEL,
        CFG_JERK,
        CFG_PERIOD
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_MOVE,
        OP_SOFT_STOP,
        OP_ESTOP
    } t_opcode;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [23:0] full_step_count;
    } t_in_item;

    typedef struct packed {
        logic               step_pulse;
        logic               direction;
        logic               moving;
        logic signed [31:0] axis_position;
        logic [15:0]        current_speed;
    } t_out_item;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MV1,
        S_MV2,
        S_SS1,
        S_SS2,
        S_BRK,
        S_VMX,
        S_SQRT,
        S_JRK,
        S_DV,
        S_FIN,
        S_PHASE,
        S_OUT
    } t_state;

endpackage

@@ design/sssg_alu.sv @@
// ----------------------------------------------------------------------------
// sssg_alu
// Shared radix-2 unit: shift-add multiply, restoring divide, integer sqrt.
// ----------------------------------------------------------------------------
module sssg_alu import sssg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_req    i_req,
    input  logic [31:0] i_a,
    input  logic [15:0] i_b,
    output t_alu_sts    o_sts,
    output logic [47:0] o_res
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    t_alu_op     r_op, n_op;
    logic [4:0]  r_cnt, n_cnt;
    logic [47:0] r_x, n_x;
    logic [31:0] r_y, n_y;
    logic [47:0] r_z, n_z;

    always_comb begin
        logic [17:0] rem;
        logic [32:0] sum;
        logic        qb;
        logic [4:0]  last;
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        rem    = '0;
        sum    = '0;
        qb     = 1'b0;
        case (r_op)
            ALU_DIV: last = 5'(DIV_STEPS - 1);
            ALU_SQRT: last = 5'(SQRT_STEPS - 1);
            default: last = 5'(MUL_STEPS - 1);
        endcase
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = '0;
            n_x    = {16'b0, i_a};
            n_z    = '0;
            if (i_req.op == ALU_SQRT) begin
                n_y = SQRT_BIT0;
            end else begin
                n_y = {16'b0, i_b};
            end
        end else if (r_busy) begin
            n_cnt = r_cnt + 5'd1;
            case (r_op)
                ALU_DIV: begin
                    rem = {r_z[16:0], r_x[31]};
                    if (rem >= {2'b0, r_y[15:0]}) begin
                        rem = rem - {2'b0, r_y[15:0]};
                        qb  = 1'b1;
                    end
                    n_z = {30'b0, rem};
                    n_x = {16'b0, r_x[30:0], qb};
                end
                ALU_SQRT: begin
                    sum = {1'b0, r_z[31:0]} + {1'b0, r_y};
                    if ({1'b0, r_x[31:0]} >= sum) begin
                        n_x = {16'b0, r_x[31:0] - sum[31:0]};
                        n_z = {16'b0, {1'b0, r_z[31:1]} + r_y};
                    end else begin
                        n_z = {17'b0, r_z[31:1]};
                    end
                    n_y = {2'b0, r_y[31:2]};
                end
                default: begin
                    if (r_y[0]) begin
                        n_z = r_z + r_x;
                    end
                    n_x = {r_x[46:0], 1'b0};
                    n_y = {1'b0, r_y[31:1]};
                end
            endcase
            if (r_cnt == last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    always_comb begin
        case (r_op)
            ALU_DIV: o_res = {16'b0, r_x[31:0]};
            default: o_res = r_z;
        endcase
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

@@ design/stepper_scurve_step_generator_unit.sv @@
// ----------------------------------------------------------------------------
// stepper_scurve_step_generator_unit
// Per item, with the output free: a tick without profile update runs at most
//   the phase step; a tick with profile update adds five passes of the shared
//   mul/div/sqrt unit; move and soft stop use it at most twice; emergency stop
//   goes straight to the result. One item at a time; the result is registered.
// Synchronous active-low reset loads register defaults and clears axis state.
// ----------------------------------------------------------------------------
module stepper_scurve_step_generator_unit import sssg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_tick, r_min, r_max, r_ssf;
    logic [8:0]  r_micro;
    logic [14:0] r_accel, r_jerk;
    logic [9:0]  r_period;

    logic [31:0]        r_pos, n_pos;
    logic [31:0]        r_steps, n_steps;
    logic [15:0]        r_speed, n_speed;
    logic [15:0]        r_goal, n_goal;
    logic signed [31:0] r_acc, n_acc;
    logic [16:0]        r_pa, n_pa;
    logic               r_hold, n_hold;
    logic [9:0]         r_pc, n_pc;
    logic               r_dir, n_dir;
    logic               r_active, n_active;

    t_state             r_state, n_state;
    t_in_item           r_in, n_in;
    logic               r_pulse, n_pulse;
    logic [47:0]        r_t48, n_t48;
    logic               r_err_pos, n_err_pos;
    logic               r_err_neg, n_err_neg;
    logic signed [9:0]  r_dv, n_dv;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    t_alu_req    alu_req;
    t_alu_sts    alu_sts;
    logic [31:0] alu_a;
    logic [15:0] alu_b;
    logic [47:0] alu_res;

    logic [15:0] eff_tick;
    logic [15:0] vmax;
    logic [23:0] mag;
    logic        in_xfer;

    assign eff_tick = (r_tick == '0) ? 16'd1 : r_tick;
    assign vmax     = eff_tick - 16'd1;
    assign mag      = r_in.full_step_count[23] ? 24'(-r_in.full_step_count)
                                               : r_in.full_step_count;
    assign in_xfer  = i_in_valid && !o_in_stall;

    sssg_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_sts   (alu_sts),
        .o_res   (alu_res)
    );

    always_comb begin
        logic [9:0]         pc_inc;
        logic [24:0]        sv;
        logic [15:0]        stop_v, lim;
        logic signed [33:0] tgt, amax, acc34, j34, ramp;
        logic [40:0]        prod;
        logic [9:0]         dvmag;
        logic signed [9:0]  dv2;
        logic signed [17:0] nv;
        logic [16:0]        pa_sum;
        logic               alu_state;

        n_pos = r_pos;   n_steps = r_steps; n_speed = r_speed; n_goal = r_goal;
        n_acc = r_acc;   n_pa = r_pa;       n_hold = r_hold;   n_pc = r_pc;
        n_dir = r_dir;   n_active = r_active;
        n_state = r_state; n_in = r_in; n_pulse = r_pulse; n_t48 = r_t48;
        n_err_pos = r_err_pos; n_err_neg = r_err_neg; n_dv = r_dv;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        alu_state = 1'b0;
        alu_req.op = ALU_MUL;
        alu_a = '0;
        alu_b = '0;
        pc_inc = r_pc + 10'd1;
        sv = alu_res[24:0];
        stop_v = alu_res[15:0];
        lim = '0;
        amax = signed'({3'b0, r_accel, 16'b0});
        tgt = '0;
        acc34 = {{2{r_acc[31]}}, r_acc};
        j34 = {10'b0, alu_res[23:0]};
        ramp = acc34;
        prod = alu_res[40:0];
        dvmag = '0;
        dv2 = r_dv;
        nv = '0;
        pa_sum = r_pa + {1'b0, r_speed};

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_in = i_in_data;
                    n_pulse = 1'b0;
                    case (t_opcode'(i_in_data.operation))
                        OP_TICK: begin
                            if (!r_active) begin
                                n_state = S_OUT;
                            end else if (pc_inc >= r_period) begin
                                n_pc = '0;
                                if (r_steps == '0) begin
                                    n_active = 1'b0;
                                    n_state = S_OUT;
                                end else begin
                                    n_state = S_BRK;
                                end
                            end else begin
                                n_pc = pc_inc;
                                n_state = S_PHASE;
                            end
                        end
                        OP_MOVE: begin
                            if (i_in_data.full_step_count == '0) begin
                                n_state = S_OUT;
                            end else begin
                                n_dir = ~i_in_data.full_step_count[23];
                                n_hold = 1'b1;
                                n_state = S_MV1;
                            end
                        end
                        OP_SOFT_STOP: begin
                            n_goal = r_min;
                            if (r_accel == '0) begin
                                n_steps = '1;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_SS1;
                            end
                        end
                        default: begin
                            n_active = 1'b0;
                            n_steps = '0;
                            n_speed = '0;
                            n_pa = '0;
                            n_acc = '0;
                            n_pc = '0;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_MV1: begin
                alu_state = 1'b1;
                alu_a = {8'b0, mag};
                alu_b = {7'b0, r_micro};
                if (alu_sts.done) begin
                    n_steps = alu_res[31:0];
                    n_state = S_MV2;
                end
            end
            S_MV2: begin
                alu_state = 1'b1;
                alu_a = {16'b0, r_ssf};
                alu_b = {7'b0, r_micro};
                if (alu_sts.done) begin
                    if (sv > 25'h00FFFF) begin
                        n_speed = 16'hFFFF;
                    end else if (sv[15:0] < r_min) begin
                        n_speed = r_min;
                    end else begin
                        n_speed = sv[15:0];
                    end
                    n_goal = n_speed;
                    n_acc = '0;
                    n_pa = '0;
                    n_pc = '0;
                    n_active = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_SS1: begin
                alu_state = 1'b1;
                alu_a = {16'b0, r_speed};
                alu_b = r_speed;
                if (alu_sts.done) begin
                    n_t48 = alu_res;
                    n_state = S_SS2;
                end
            end
            S_SS2: begin
                alu_state = 1'b1;
                alu_req.op = ALU_DIV;
                alu_a = r_t48[31:0];
                alu_b = {r_accel, 1'b0};
                if (alu_sts.done) begin
                    n_steps = alu_res[31:0];
                    n_state = S_OUT;
                end
            end
            S_BRK: begin
                alu_state = 1'b1;
                alu_a = r_steps;
                alu_b = {1'b0, r_accel};
                if (alu_sts.done) begin
                    n_t48 = {alu_res[46:0], 1'b0};
                    n_state = S_VMX;
                end
            end
            S_VMX: begin
                alu_state = 1'b1;
                alu_a = {16'b0, vmax};
                alu_b = vmax;
                if (alu_sts.done) begin
                    if (r_t48 > alu_res) begin
                        n_t48 = alu_res;
                    end
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                alu_state = 1'b1;
                alu_req.op = ALU_SQRT;
                alu_a = r_t48[31:0];
                if (alu_sts.done) begin
                    lim = (stop_v < r_max) ? stop_v : r_max;
                    if (lim < r_min) begin
                        lim = r_min;
                    end
                    n_goal = lim;
                    n_err_pos = lim > r_speed;
                    n_err_neg = lim < r_speed;
                    n_state = S_JRK;
                end
            end
            S_JRK: begin
                alu_state = 1'b1;
                alu_a = {23'b0, DT_Q16};
                alu_b = {1'b0, r_jerk};
                if (alu_sts.done) begin
                    if (r_err_pos) begin
                        tgt = amax;
                    end else if (r_err_neg) begin
                        tgt = -amax;
                    end
                    if (acc34 < tgt) begin
                        ramp = acc34 + j34;
                        if (ramp > tgt) begin
                            ramp = tgt;
                        end
                    end else if (acc34 > tgt) begin
                        ramp = acc34 - j34;
                        if (ramp < tgt) begin
                            ramp = tgt;
                        end
                    end
                    n_acc = ramp[31:0];
                    n_state = S_DV;
                end
            end
            S_DV: begin
                alu_state = 1'b1;
                alu_a = r_acc[31] ? 32'(-r_acc) : r_acc;
                alu_b = {7'b0, DT_Q16};
                if (alu_sts.done) begin
                    if (r_acc[31]) begin
                        dvmag = {1'b0, prod[40:32]} + 10'(prod[31:0] != '0);
                        n_dv = -signed'(dvmag);
                    end else begin
                        n_dv = signed'({1'b0, prod[40:32]});
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_dv == '0 && r_err_pos) begin
                    dv2 = 10'sd1;
                end else if (r_dv == '0 && r_err_neg) begin
                    dv2 = -10'sd1;
                end
                nv = signed'({2'b0, r_speed}) + 18'(dv2);
                if ((r_err_pos && nv > signed'({2'b0, r_goal})) ||
                    (r_err_neg && nv < signed'({2'b0, r_goal}))) begin
                    nv = signed'({2'b0, r_goal});
                    n_acc = '0;
                end
                if (nv < signed'({2'b0, r_min})) begin
                    nv = signed'({2'b0, r_min});
                end
                if (nv >= signed'({2'b0, eff_tick})) begin
                    nv = signed'({2'b0, vmax});
                end
                n_speed = nv[15:0];
                n_state = S_PHASE;
            end
            S_PHASE: begin
                n_state = S_OUT;
                if (r_hold) begin
                    n_hold = 1'b0;
                end else if (pa_sum < {1'b0, eff_tick}) begin
                    n_pa = pa_sum;
                end else begin
                    n_pa = pa_sum - {1'b0, eff_tick};
                    n_pos = r_pos + (r_dir ? 32'd1 : 32'hFFFF_FFFF);
                    n_pulse = 1'b1;
                    if (r_steps <= 32'd1) begin
                        n_active = 1'b0;
                        n_steps = '0;
                        n_acc = '0;
                        n_speed = r_min;
                    end else begin
                        n_steps = r_steps - 32'd1;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.step_pulse = r_pulse;
                    n_out.direction = r_dir;
                    n_out.moving = r_active;
                    n_out.axis_position = r_pos;
                    n_out.current_speed = r_speed;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        alu_req.start = alu_state && !alu_sts.busy && !alu_sts.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= RST_TICK_RATE;
            r_micro  <= RST_MICRO;
            r_min    <= RST_MIN_SPEED;
            r_max    <= RST_MAX_SPEED;
            r_ssf    <= RST_START_FS;
            r_accel  <= RST_ACCEL;
            r_jerk   <= RST_JERK;
            r_period <= RST_PERIOD;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TICK_RATE: r_tick <= i_cfg_data;
                CFG_MICROSTEPS: r_micro <= i_cfg_data[8:0];
                CFG_MIN_SPEED: r_min <= i_cfg_data;
                CFG_MAX_SPEED: r_max <= i_cfg_data;
                CFG_START_SPEED: r_ssf <= i_cfg_data;
                CFG_ACCEL: r_accel <= i_cfg_data[14:0];
                CFG_JERK: r_jerk <= i_cfg_data[14:0];
                CFG_PERIOD: r_period <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_steps     <= '0;
            r_speed     <= RST_MIN_SPEED;
            r_goal      <= RST_MIN_SPEED;
            r_acc       <= '0;
            r_pa        <= '0;
            r_hold      <= 1'b0;
            r_pc        <= '0;
            r_dir       <= 1'b0;
            r_active    <= 1'b0;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_steps     <= n_steps;
            r_speed     <= n_speed;
            r_goal      <= n_goal;
            r_acc       <= n_acc;
            r_pa        <= n_pa;
            r_hold      <= n_hold;
            r_pc        <= n_pc;
            r_dir       <= n_dir;
            r_active    <= n_active;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_in      <= n_in;
        r_pulse   <= n_pulse;
        r_t48     <= n_t48;
        r_err_pos <= n_err_pos;
        r_err_neg <= n_err_neg;
        r_dv      <= n_dv;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/sssg_checker.sv @@
// ----------------------------------------------------------------------------
// sssg_checker
// Port-level checks for the step generator, bound to the top level.
// ----------------------------------------------------------------------------
module sssg_checker import sssg_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_item   o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work in progress");

endmodule

bind stepper_scurve_step_generator_unit sssg_checker u_sssg_checker (.*);
